[rtl/lcdt_pkg.sv]
// Package for the LCD line and mode timing core: timing constants, mode and
// render event codes, register indexes and field types. No dependencies.
package lcdt_pkg;

    localparam int unsigned CountW = 10;
    localparam int unsigned LineW  = 8;

    typedef logic [CountW-1:0] count_t;
    typedef logic [LineW-1:0]  line_t;
    typedef logic [1:0]        mode_t;
    typedef logic [2:0]        event_t;
    typedef logic [7:0]        step_t;

    localparam count_t LINE_CYCLES  = count_t'(456);
    localparam count_t OAM_END      = count_t'(80);
    localparam count_t DRAW_END     = count_t'(289);
    localparam line_t  VBLANK_FIRST = line_t'(144);
    localparam line_t  LAST_LINE    = line_t'(153);

    localparam mode_t MODE_H_BLANK = 2'd0;
    localparam mode_t MODE_V_BLANK = 2'd1;
    localparam mode_t MODE_OAM     = 2'd2;
    localparam mode_t MODE_DRAW    = 2'd3;

    localparam event_t EV_NONE    = 3'd0;
    localparam event_t EV_SPRITES = 3'd1;
    localparam event_t EV_DRAW    = 3'd2;
    localparam event_t EV_FRAME   = 3'd3;
    localparam event_t EV_OFF     = 3'd4;

    localparam logic CMD_ADVANCE   = 1'b0;
    localparam logic CMD_LINE_RST  = 1'b1;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_DISPLAY_ENABLE = 3'd0;
    localparam reg_idx_t REG_COMPARE_LINE   = 3'd1;
    localparam reg_idx_t REG_HBLANK_IRQ_EN  = 3'd2;
    localparam reg_idx_t REG_VBLANK_IRQ_EN  = 3'd3;
    localparam reg_idx_t REG_OAM_IRQ_EN     = 3'd4;
    localparam reg_idx_t REG_COINC_IRQ_EN   = 3'd5;

    localparam int unsigned AddrW = 5;

    typedef struct packed {
        logic   cmd;
        step_t  cycle_step;
    } in_item_t;

    typedef struct packed {
        line_t  line;
        mode_t  lcd_mode;
        logic   coincidence;
        logic   stat_irq;
        logic   vblank_irq;
        event_t render_event;
        logic   frame_wrap;
    } out_item_t;

endpackage

[rtl/lcdt_in_if.sv]
// Input channel of the LCD timing core: valid/ready plus command and step.
// Depends on lcdt_pkg.
interface lcdt_in_if import lcdt_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    step_t cycle_step;

    modport source (output valid, output cmd, output cycle_step, input ready);
    modport sink   (input valid, input cmd, input cycle_step, output ready);
endinterface

[rtl/lcdt_out_if.sv]
// Result channel of the LCD timing core: valid/ready plus line, mode, flags
// and render event. Depends on lcdt_pkg.
interface lcdt_out_if import lcdt_pkg::*; ();
    logic   valid;
    logic   ready;
    line_t  line;
    mode_t  lcd_mode;
    logic   coincidence;
    logic   stat_irq;
    logic   vblank_irq;
    event_t render_event;
    logic   frame_wrap;

    modport source (output valid, output line, output lcd_mode, output coincidence,
                    output stat_irq, output vblank_irq, output render_event,
                    output frame_wrap, input ready);
    modport sink   (input valid, input line, input lcd_mode, input coincidence,
                    input stat_irq, input vblank_irq, input render_event,
                    input frame_wrap, output ready);
endinterface

[rtl/lcd_line_mode_timing_core.sv]
// Top level of the LCD line and mode timing core: APB register file, input
// register, timing update and result register. Depends on lcdt_pkg,
// lcdt_in_if and lcdt_out_if.
//
//  channel | kind        | payload                                      | accept
//  --------+-------------+----------------------------------------------+-------------------
//  req     | stream in   | cmd, cycle_step                              | valid & ready
//  rsp     | stream out  | line, lcd_mode, coincidence, stat_irq,       | valid & ready
//          |             | vblank_irq, render_event, frame_wrap         |
//  apb     | config port | paddr, pwdata, prdata (6 regs at 4*i)        | psel&penable&pwrite
//
// One transaction per clock sustained while rsp keeps taking results; an
// accepted req item is held in the input register and its result is then
// loaded into the result register, from which rsp takes it. The timing state
// updates as the item leaves the input register, so the next item sees it with no bubble.
// Reset: count 456, line 0, previous line 0, mode hblank, flag clear, all
// registers zero, both stages empty.
// Stalls: a held result blocks the input register; req.ready drops only when
// both stages are full and rsp is not taken.
module lcd_line_mode_timing_core
    import lcdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    lcdt_in_if.sink             req,
    lcdt_out_if.source          rsp
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic     display_enable_reg;
    line_t    compare_line_reg;
    logic     hblank_irq_en_reg;
    logic     vblank_irq_en_reg;
    logic     oam_irq_en_reg;
    logic     coinc_irq_en_reg;
    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[AddrW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b0;
            compare_line_reg   <= '0;
            hblank_irq_en_reg  <= 1'b0;
            vblank_irq_en_reg  <= 1'b0;
            oam_irq_en_reg     <= 1'b0;
            coinc_irq_en_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            // drop writes beyond the register list
            unique case (cfg_idx)
                REG_DISPLAY_ENABLE: display_enable_reg <= pwdata[0];
                REG_COMPARE_LINE:   compare_line_reg   <= pwdata[LineW-1:0];
                REG_HBLANK_IRQ_EN:  hblank_irq_en_reg  <= pwdata[0];
                REG_VBLANK_IRQ_EN:  vblank_irq_en_reg  <= pwdata[0];
                REG_OAM_IRQ_EN:     oam_irq_en_reg     <= pwdata[0];
                REG_COINC_IRQ_EN:   coinc_irq_en_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_DISPLAY_ENABLE: prdata[0]         = display_enable_reg;
            REG_COMPARE_LINE:   prdata[LineW-1:0] = compare_line_reg;
            REG_HBLANK_IRQ_EN:  prdata[0]         = hblank_irq_en_reg;
            REG_VBLANK_IRQ_EN:  prdata[0]         = vblank_irq_en_reg;
            REG_OAM_IRQ_EN:     prdata[0]         = oam_irq_en_reg;
            REG_COINC_IRQ_EN:   prdata[0]         = coinc_irq_en_reg;
            default:            prdata            = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register
    // ------------------------------------------------------------------
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      take_in;

    // move the held item on when the result register is empty or drained
    assign advance = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign take_in = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.cmd        <= req.cmd;
            in_item_reg.cycle_step <= req.cycle_step;
        end
    end

    // ------------------------------------------------------------------
    // Timing state
    // ------------------------------------------------------------------
    count_t cycle_count_reg,   cycle_count_next;
    line_t  current_line_reg,  current_line_next;
    line_t  previous_line_reg, previous_line_next;
    mode_t  mode_reg,          mode_next;
    logic   coinc_reg,         coinc_next;
    out_item_t result;

    count_t sum;
    line_t  line_inc;
    mode_t  pick;
    logic   line_changed;

    always_comb
    begin
        // mode from the line and the count held before this advance
        if (current_line_reg >= VBLANK_FIRST && current_line_reg <= LAST_LINE)
            pick = MODE_V_BLANK;
        else if (cycle_count_reg <= OAM_END)
            pick = MODE_OAM;
        else if (cycle_count_reg <= DRAW_END)
            pick = MODE_DRAW;
        else
            pick = MODE_H_BLANK;

        sum          = cycle_count_reg + count_t'(in_item_reg.cycle_step);
        line_inc     = current_line_reg + line_t'(1);
        line_changed = previous_line_reg != current_line_reg;

        cycle_count_next   = cycle_count_reg;
        current_line_next  = current_line_reg;
        previous_line_next = previous_line_reg;
        mode_next          = mode_reg;
        coinc_next         = coinc_reg;

        result.stat_irq     = 1'b0;
        result.vblank_irq   = 1'b0;
        result.render_event = EV_NONE;
        result.frame_wrap   = 1'b0;

        priority if (in_item_reg.cmd == CMD_LINE_RST)
        begin
            // LY write: only the line counter moves
            current_line_next = '0;
        end
        else if (!display_enable_reg)
        begin
            // hold timing in reset while the display is off
            cycle_count_next    = LINE_CYCLES;
            current_line_next   = '0;
            mode_next           = MODE_H_BLANK;
            result.render_event = EV_OFF;
        end
        else
        begin
            if (line_changed)
            begin
                coinc_next = current_line_reg == compare_line_reg;
                if (coinc_next && coinc_irq_en_reg)
                    result.stat_irq = 1'b1;
            end
            mode_next = pick;

            if (mode_reg != pick)
            begin
                unique case (pick)
                    MODE_OAM:
                    begin
                        result.render_event = EV_SPRITES;
                        if (oam_irq_en_reg)
                            result.stat_irq = 1'b1;
                    end
                    MODE_DRAW:
                        result.render_event = EV_DRAW;
                    MODE_H_BLANK:
                    begin
                        if (hblank_irq_en_reg)
                            result.stat_irq = 1'b1;
                    end
                    MODE_V_BLANK:
                    begin
                        result.render_event = EV_FRAME;
                        if (vblank_irq_en_reg)
                            result.stat_irq = 1'b1;
                        else
                            result.vblank_irq = 1'b1;
                    end
                endcase
            end

            previous_line_next = current_line_reg;
            cycle_count_next   = sum;
            // end of line: restart the count and drop the leftover cycles
            if (sum >= LINE_CYCLES)
            begin
                cycle_count_next = '0;
                if (current_line_reg >= LAST_LINE)
                begin
                    current_line_next = '0;
                    result.frame_wrap = 1'b1;
                end
                else
                    current_line_next = line_inc;
            end
        end

        result.line        = current_line_next;
        result.lcd_mode    = mode_next;
        result.coincidence = coinc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg   <= LINE_CYCLES;
            current_line_reg  <= '0;
            previous_line_reg <= '0;
            mode_reg          <= MODE_H_BLANK;
            coinc_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            cycle_count_reg   <= cycle_count_next;
            current_line_reg  <= current_line_next;
            previous_line_reg <= previous_line_next;
            mode_reg          <= mode_next;
            coinc_reg         <= coinc_next;
            out_valid_reg     <= 1'b1;
        end
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
            out_item_reg <= result;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.line         = out_item_reg.line;
    assign rsp.lcd_mode     = out_item_reg.lcd_mode;
    assign rsp.coincidence  = out_item_reg.coincidence;
    assign rsp.stat_irq     = out_item_reg.stat_irq;
    assign rsp.vblank_irq   = out_item_reg.vblank_irq;
    assign rsp.render_event = out_item_reg.render_event;
    assign rsp.frame_wrap   = out_item_reg.frame_wrap;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cycle_count_reg <= LINE_CYCLES)
        else $error("cycle count beyond line length");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        current_line_reg <= LAST_LINE)
        else $error("line counter beyond last line");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> $stable(cycle_count_reg) && $stable(current_line_reg))
        else $error("timing state moved while result stalled");

    a_wrap_line0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.frame_wrap |-> out_item_reg.line == '0)
        else $error("frame wrap without line 0");

    a_vbl_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.vblank_irq |-> out_item_reg.render_event == EV_FRAME)
        else $error("vblank interrupt without frame event");

endmodule

[tb/lcd_line_mode_timing_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lcd_line_mode_timing_core: drives timing commands,
// predicts line, mode, flags, irqs and render events, and checks every result.
// Depends on lcdt_pkg, lcdt_in_if, lcdt_out_if and the core itself.
module lcd_line_mode_timing_core_test;
    import lcdt_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 6;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    lcdt_in_if  req_if ();
    lcdt_out_if rsp_if ();

    lcd_line_mode_timing_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    // Shadow copy of the register file, updated as each APB write lands.
    logic  cfg_enable;
    line_t cfg_compare;
    logic  cfg_hblank_irq;
    logic  cfg_vblank_irq;
    logic  cfg_oam_irq;
    logic  cfg_coinc_irq;

    // Predicted timing state of the core.
    count_t lcd_cycles;
    line_t  lcd_line;
    line_t  lcd_prev_line;
    mode_t  lcd_mode;
    logic   lcd_coinc;

    in_item_t  pending_steps_q[$];
    out_item_t expected_status_q[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned wraps_seen;
    int unsigned vblank_irqs_seen;
    int unsigned stat_irqs_seen;
    int unsigned tb_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Advance the predicted timing by one command and return the status it reports.
    function automatic out_item_t advance_timing(input in_item_t item);
        out_item_t res;
        mode_t     entered;
        res = '0;
        if (item.cmd == CMD_LINE_RST)
        begin
            // LY write: only the line counter clears, everything else holds
            lcd_line = '0;
        end
        else if (!cfg_enable)
        begin
            // display off: timing held at the start of an invisible line
            lcd_cycles = LINE_CYCLES;
            lcd_line   = '0;
            lcd_mode   = MODE_H_BLANK;
            res.render_event = EV_OFF;
        end
        else
        begin
            // mode is picked from the count before this step's cycles are added
            if (lcd_line >= VBLANK_FIRST && lcd_line <= LAST_LINE)
                entered = MODE_V_BLANK;
            else if (lcd_cycles <= OAM_END)
                entered = MODE_OAM;
            else if (lcd_cycles <= DRAW_END)
                entered = MODE_DRAW;
            else
                entered = MODE_H_BLANK;

            if (lcd_prev_line != lcd_line)
            begin
                lcd_coinc = (lcd_line == cfg_compare);
                if (lcd_coinc && cfg_coinc_irq)
                    res.stat_irq = 1'b1;
            end

            if (entered != lcd_mode)
            begin
                case (entered)
                    MODE_OAM:
                    begin
                        res.render_event = EV_SPRITES;
                        if (cfg_oam_irq)
                            res.stat_irq = 1'b1;
                    end
                    MODE_DRAW:
                        res.render_event = EV_DRAW;
                    MODE_H_BLANK:
                    begin
                        if (cfg_hblank_irq)
                            res.stat_irq = 1'b1;
                    end
                    default:
                    begin
                        res.render_event = EV_FRAME;
                        if (cfg_vblank_irq)
                            res.stat_irq = 1'b1;
                        else
                            res.vblank_irq = 1'b1;
                    end
                endcase
            end
            lcd_mode = entered;

            // 10-bit sum; leftover cycles past the line end are dropped
            lcd_cycles    = lcd_cycles + count_t'(item.cycle_step);
            lcd_prev_line = lcd_line;
            if (lcd_cycles >= LINE_CYCLES)
            begin
                lcd_line   = lcd_line + line_t'(1);
                lcd_cycles = '0;
            end
            if (lcd_line > LAST_LINE)
            begin
                lcd_line      = '0;
                res.frame_wrap = 1'b1;
            end
        end
        res.line        = lcd_line;
        res.lcd_mode    = lcd_mode;
        res.coincidence = lcd_coinc;
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Request driver: hold the front transaction until accepted, then advance.
    always @(posedge clk)
    begin : drive_requests
        logic stalled;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            stalled = req_if.valid && !req_if.ready;
            if (req_if.valid && req_if.ready)
            begin
                expected_status_q.push_back(advance_timing(pending_steps_q.pop_front()));
                items_sent++;
            end
            if (!stalled)
            begin
                if (pending_steps_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_if.valid      <= 1'b1;
                    req_if.cmd        <= pending_steps_q[0].cmd;
                    req_if.cycle_step <= pending_steps_q[0].cycle_step;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted status against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_status_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual line %0d mode %0d",
                             $time, rsp_if.line, rsp_if.lcd_mode);
                    mismatches++;
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    check_field("line", int'(want.line), int'(rsp_if.line));
                    check_field("lcd_mode", int'(want.lcd_mode), int'(rsp_if.lcd_mode));
                    check_field("coincidence", int'(want.coincidence),
                                int'(rsp_if.coincidence));
                    check_field("stat_irq", int'(want.stat_irq), int'(rsp_if.stat_irq));
                    check_field("vblank_irq", int'(want.vblank_irq), int'(rsp_if.vblank_irq));
                    check_field("render_event", int'(want.render_event),
                                int'(rsp_if.render_event));
                    check_field("frame_wrap", int'(want.frame_wrap), int'(rsp_if.frame_wrap));
                    results_checked++;
                    wraps_seen       += 32'(rsp_if.frame_wrap);
                    vblank_irqs_seen += 32'(rsp_if.vblank_irq);
                    stat_irqs_seen   += 32'(rsp_if.stat_irq);
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run with errors if the whole test runs past LIMIT_CYCLES.
    always @(posedge clk)
    begin
        tb_cycles++;
        if (tb_cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     tb_cycles, expected_status_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle; the register lands at the end of the access cycle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DISPLAY_ENABLE: cfg_enable     = value[0];
            REG_COMPARE_LINE:   cfg_compare    = value[7:0];
            REG_HBLANK_IRQ_EN:  cfg_hblank_irq = value[0];
            REG_VBLANK_IRQ_EN:  cfg_vblank_irq = value[0];
            REG_OAM_IRQ_EN:     cfg_oam_irq    = value[0];
            REG_COINC_IRQ_EN:   cfg_coinc_irq  = value[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic enable, input line_t compare, input logic hb_irq,
                                 input logic vb_irq, input logic oam_irq, input logic ly_irq);
        write_reg(REG_DISPLAY_ENABLE, 32'(enable));
        write_reg(REG_COMPARE_LINE, 32'(compare));
        write_reg(REG_HBLANK_IRQ_EN, 32'(hb_irq));
        write_reg(REG_VBLANK_IRQ_EN, 32'(vb_irq));
        write_reg(REG_OAM_IRQ_EN, 32'(oam_irq));
        write_reg(REG_COINC_IRQ_EN, 32'(ly_irq));
    endtask

    task automatic queue_step(input logic cmd, input step_t cycles);
        in_item_t item;
        item.cmd        = cmd;
        item.cycle_step = cycles;
        pending_steps_q.push_back(item);
    endtask

    // Wait until every transaction has been sent and answered, then let the
    // pipeline settle before touching the registers.
    task automatic wait_idle();
        while (pending_steps_q.size() != 0 || expected_status_q.size() != 0 || req_if.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random traffic: mostly advances, biased toward long steps so frames wrap.
    task automatic queue_random_steps(input int unsigned count, input int unsigned rst_pct);
        int unsigned pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < rst_pct)
                queue_step(CMD_LINE_RST, step_t'($urandom_range(255)));
            else if (pick < rst_pct + 10)
                queue_step(CMD_ADVANCE, step_t'($urandom_range(7)));
            else if (pick < rst_pct + 40)
                queue_step(CMD_ADVANCE, step_t'($urandom_range(255, 200)));
            else
                queue_step(CMD_ADVANCE, step_t'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input logic enable, input line_t compare, input logic hb_irq,
                             input logic vb_irq, input logic oam_irq, input logic ly_irq,
                             input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count, input int unsigned rst_pct);
        wait_idle();
        load_settings(enable, compare, hb_irq, vb_irq, oam_irq, ly_irq);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_steps(count, rst_pct);
        wait_idle();
    endtask

    initial
    begin
        // drive every input to a known value before the first edge
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_if.valid   = 1'b0;
        req_if.cmd     = CMD_ADVANCE;
        req_if.cycle_step = '0;
        rsp_if.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        items_sent     = 0;
        results_checked  = 0;
        wraps_seen       = 0;
        vblank_irqs_seen = 0;
        stat_irqs_seen   = 0;
        tb_cycles      = 0;

        // reset state of the predictor mirrors the core after reset
        cfg_enable     = 1'b0;
        cfg_compare    = '0;
        cfg_hblank_irq = 1'b0;
        cfg_vblank_irq = 1'b0;
        cfg_oam_irq    = 1'b0;
        cfg_coinc_irq  = 1'b0;
        lcd_cycles     = LINE_CYCLES;
        lcd_line       = '0;
        lcd_prev_line  = '0;
        lcd_mode       = MODE_H_BLANK;
        lcd_coinc      = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: display off, both commands, extreme steps
        load_settings(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_step(CMD_ADVANCE, 8'd0);
        queue_step(CMD_ADVANCE, 8'd255);
        queue_step(CMD_LINE_RST, 8'd0);
        queue_step(CMD_ADVANCE, 8'd17);
        wait_idle();

        // Directed: display on, walk one line through the OAM, drawing and hblank entries
        load_settings(1'b1, 8'd1, 1'b1, 1'b0, 1'b1, 1'b1);
        queue_step(CMD_ADVANCE, 8'd255);  // finish the off line, move to line 1
        queue_step(CMD_ADVANCE, 8'd0);    // coincidence match and OAM entry together
        queue_step(CMD_ADVANCE, 8'd80);
        queue_step(CMD_ADVANCE, 8'd1);
        queue_step(CMD_ADVANCE, 8'd208);  // drawing entry
        queue_step(CMD_ADVANCE, 8'd1);
        queue_step(CMD_ADVANCE, 8'd0);    // hblank entry
        queue_step(CMD_LINE_RST, 8'd255); // step is ignored on a line reset
        queue_step(CMD_ADVANCE, 8'd255);  // line change away from the compare line
        queue_step(CMD_ADVANCE, 8'd0);
        queue_step(CMD_ADVANCE, 8'd255);
        queue_step(CMD_ADVANCE, 8'd255);
        queue_step(CMD_ADVANCE, 8'd128);
        queue_step(CMD_ADVANCE, 8'd255);
        queue_step(CMD_LINE_RST, 8'd0);
        queue_step(CMD_ADVANCE, 8'd0);
        wait_idle();

        // Random phases: sweep compare extremes and irq enables across the
        // four idle patterns; early phases skip line resets so frames wrap.
        run_phase(1'b1, 8'd0,   1'b1, 1'b0, 1'b1, 1'b1, 0,  0,  300, 0);
        run_phase(1'b1, 8'd255, 1'b0, 1'b1, 1'b0, 1'b1, 81, 0,  200, 0);
        run_phase(1'b1, 8'd153, 1'b1, 1'b1, 1'b1, 1'b0, 0,  81, 200, 0);
        run_phase(1'b1, 8'd144, 1'b0, 1'b0, 1'b0, 1'b1, 14, 14, 200, 0);
        run_phase(1'b0, line_t'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  0, 0, 60, 30);
        run_phase(1'b1, line_t'($urandom_range(153)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  81, 0, 200, 0);
        run_phase(1'b1, line_t'($urandom_range(153)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  0, 81, 200, 2);
        run_phase(1'b1, line_t'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  14, 14, 170, 2);

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Run covered %0d timing transactions over two directed and eight random phases;",
                 items_sent);
        $display("%0d results checked, %0d frame wraps, %0d vblank irqs, %0d status irqs.",
                 results_checked, wraps_seen, vblank_irqs_seen, stat_irqs_seen);
        if (mismatches == 0 && expected_status_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
